### hdl/packed_sorted_array_search_macros.svh
// packed_sorted_array_search_macros.svh
// assertion macros shared by the checker of the sorted array search engine
// no dependencies
`ifndef PACKED_SORTED_ARRAY_SEARCH_MACROS_SVH
`define PACKED_SORTED_ARRAY_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSAS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted array search check failed");

// next-cycle implication, disabled during reset
`define PSAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted array search check failed");

`endif

### hdl/psas_pkg.sv
// psas_pkg.sv
// sizes, operation codes and controller/datapath interface types of the
// sorted array search engine; no dependencies
package psas_pkg;

   localparam int DEPTH       = 1024;
   localparam int ELEM_BITS   = 32;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int POS_BITS    = $clog2(DEPTH + 1);
   localparam int LEN_BITS    = 11;
   localparam int KEY_BITS    = 32;
   localparam int RESULT_BITS = 32;
   localparam int ACTION_BITS = 3;

   // operation codes of a request
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_WRITE  = 3'd0,
      ACT_READ   = 3'd1,
      ACT_LOWER  = 3'd2,
      ACT_UPPER  = 3'd3,
      ACT_EXACT  = 3'd4,
      ACT_GALLOP = 3'd5,
      ACT_MAX    = 3'd6
   } action_type;

   // memory address source
   typedef enum logic [2:0] {
      ADDR_INDEX,
      ADDR_PROBE,
      ADDR_LO,
      ADDR_GALLOP,
      ADDR_SCAN,
      ADDR_CLEAR
   } addr_sel_type;

   // update of the bisection window
   typedef enum logic [2:0] {
      SPAN_HOLD,
      SPAN_RANGE,
      SPAN_TAIL,
      SPAN_STEP,
      SPAN_BISECT
   } span_op_type;

   // result source at the end of a transaction
   typedef enum logic [2:0] {
      RES_ERROR,
      RES_KEY,
      RES_RDATA,
      RES_LO,
      RES_LEN,
      RES_MAX,
      RES_EXACT
   } res_sel_type;

   typedef struct packed {
      logic         load;
      logic         mem_we;
      addr_sel_type addr_sel;
      span_op_type  span_op;
      logic         gal_init;
      logic         gal_step;
      logic         max_init;
      logic         max_run;
      logic         clear_run;
      logic         finish;
      res_sel_type  res_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       bad_req;
      logic       span_zero;
      logic       lo_ne_end;
      logic       go_right;
      logic       gal_in_range;
      logic       ge_key;
      logic       max_done;
      logic       clear_last;
   } dp_status_type;

endpackage

### hdl/psas_ram.sv
// psas_ram.sv
// generic single-port ram with registered read data
// no dependencies
module psas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read before write on the same address, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/psas_ctrl.sv
// psas_ctrl.sv
// controller state machine of the sorted array search engine
// depends on psas_pkg
module psas_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  psas_pkg::dp_status_type status,
   output psas_pkg::ctrl_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_READ_WAIT,
      S_BIS_ADDR,
      S_BIS_CMP,
      S_EXACT_CMP,
      S_GAL_CHECK,
      S_GAL_CMP,
      S_MAX
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff;

   // next state and datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = psas_pkg::ADDR_CLEAR;
            cmd.clear_run = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.bad_req) begin
               cmd.finish  = 1'b1;
               cmd.res_sel = psas_pkg::RES_ERROR;
               state_in    = S_IDLE;
            end else begin
               unique case (status.action)
                  psas_pkg::ACT_WRITE: begin
                     cmd.mem_we   = 1'b1;
                     cmd.addr_sel = psas_pkg::ADDR_INDEX;
                     cmd.finish   = 1'b1;
                     cmd.res_sel  = psas_pkg::RES_KEY;
                     state_in     = S_IDLE;
                  end
                  psas_pkg::ACT_READ: begin
                     cmd.addr_sel = psas_pkg::ADDR_INDEX;
                     state_in     = S_READ_WAIT;
                  end
                  psas_pkg::ACT_LOWER, psas_pkg::ACT_UPPER, psas_pkg::ACT_EXACT: begin
                     cmd.span_op = psas_pkg::SPAN_RANGE;
                     state_in    = S_BIS_ADDR;
                  end
                  psas_pkg::ACT_GALLOP: begin
                     cmd.gal_init = 1'b1;
                     state_in     = S_GAL_CHECK;
                  end
                  psas_pkg::ACT_MAX: begin
                     cmd.max_init = 1'b1;
                     state_in     = S_MAX;
                  end
                  default: begin
                     cmd.finish  = 1'b1;
                     cmd.res_sel = psas_pkg::RES_ERROR;
                     state_in    = S_IDLE;
                  end
               endcase
            end
         end
         S_READ_WAIT: begin
            cmd.finish  = 1'b1;
            cmd.res_sel = psas_pkg::RES_RDATA;
            state_in    = S_IDLE;
         end
         // window empty: answer, or fetch the candidate for an exact match; else fetch the probe
         S_BIS_ADDR: begin
            if (status.span_zero) begin
               if (status.action == psas_pkg::ACT_EXACT) begin
                  if (status.lo_ne_end) begin
                     cmd.addr_sel = psas_pkg::ADDR_LO;
                     state_in     = S_EXACT_CMP;
                  end else begin
                     cmd.finish  = 1'b1;
                     cmd.res_sel = psas_pkg::RES_LEN;
                     state_in    = S_IDLE;
                  end
               end else begin
                  cmd.finish  = 1'b1;
                  cmd.res_sel = psas_pkg::RES_LO;
                  state_in    = S_IDLE;
               end
            end else begin
               cmd.addr_sel = psas_pkg::ADDR_PROBE;
               state_in     = S_BIS_CMP;
            end
         end
         S_BIS_CMP: begin
            cmd.span_op = psas_pkg::SPAN_BISECT;
            state_in    = S_BIS_ADDR;
         end
         S_EXACT_CMP: begin
            cmd.finish  = 1'b1;
            cmd.res_sel = psas_pkg::RES_EXACT;
            state_in    = S_IDLE;
         end
         // gallop probes lo+step while it stays inside the range
         S_GAL_CHECK: begin
            if (status.gal_in_range) begin
               cmd.addr_sel = psas_pkg::ADDR_GALLOP;
               state_in     = S_GAL_CMP;
            end else begin
               cmd.span_op = psas_pkg::SPAN_TAIL;
               state_in    = S_BIS_ADDR;
            end
         end
         S_GAL_CMP: begin
            if (status.ge_key) begin
               cmd.span_op = psas_pkg::SPAN_STEP;
               state_in    = S_BIS_ADDR;
            end else begin
               cmd.gal_step = 1'b1;
               state_in     = S_GAL_CHECK;
            end
         end
         S_MAX: begin
            if (status.max_done) begin
               cmd.finish  = 1'b1;
               cmd.res_sel = psas_pkg::RES_MAX;
               state_in    = S_IDLE;
            end else begin
               cmd.addr_sel = psas_pkg::ADDR_SCAN;
               cmd.max_run  = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.finish;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

### hdl/psas_dp.sv
// psas_dp.sv
// datapath of the sorted array search engine: request latch, length register,
// bisection and gallop window, max scan, element memory and result register
// depends on psas_pkg and psas_ram
module psas_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  psas_pkg::ctrl_cmd_type                cmd,
   output psas_pkg::dp_status_type               status,
   input  logic [psas_pkg::ACTION_BITS-1:0]      req_action,
   input  logic [psas_pkg::ADDR_BITS-1:0]        req_index,
   input  logic [psas_pkg::KEY_BITS-1:0]         req_data_value,
   input  logic [psas_pkg::POS_BITS-1:0]         req_range_start,
   input  logic [psas_pkg::POS_BITS-1:0]         req_range_end,
   input  logic                                  csr_write_enable,
   input  logic [psas_pkg::LEN_BITS-1:0]         csr_write_data,
   output logic [psas_pkg::RESULT_BITS-1:0]      rsp_result,
   output logic                                  rsp_error
);

   // request latch
   psas_pkg::action_type                action_ff;
   logic [psas_pkg::ADDR_BITS-1:0]      index_ff;
   logic [psas_pkg::KEY_BITS-1:0]       key_ff;
   logic [psas_pkg::POS_BITS-1:0]       start_ff;
   logic [psas_pkg::POS_BITS-1:0]       end_ff;

   // search and scan state
   logic [psas_pkg::LEN_BITS-1:0]       len_ff;
   logic [psas_pkg::POS_BITS-1:0]       lo_ff;
   logic [psas_pkg::POS_BITS-1:0]       span_ff;
   logic [psas_pkg::POS_BITS-1:0]       step_ff;
   logic [psas_pkg::ELEM_BITS-1:0]      max_ff;
   logic [psas_pkg::POS_BITS-1:0]       scan_cnt_ff;
   logic                                scan_pend_ff;
   logic [psas_pkg::ADDR_BITS-1:0]      clear_cnt_ff;
   logic [psas_pkg::RESULT_BITS-1:0]    result_ff;
   logic                                error_ff;

   logic [psas_pkg::POS_BITS-1:0]       len_eff;
   logic [psas_pkg::POS_BITS-1:0]       half;
   logic [psas_pkg::POS_BITS-1:0]       probe;
   logic [psas_pkg::POS_BITS:0]         gal_sum;
   logic                                idx_bad;
   logic                                range_bad;
   logic                                go_right;
   logic                                scan_issue;
   logic [psas_pkg::KEY_BITS-1:0]       elem;
   logic [psas_pkg::RESULT_BITS-1:0]    result_in;
   logic [psas_pkg::ADDR_BITS-1:0]      mem_addr;
   logic [psas_pkg::ELEM_BITS-1:0]      mem_wdata;
   logic [psas_pkg::ELEM_BITS-1:0]      mem_rdata;

   // effective length, capped at the store depth
   assign len_eff = (len_ff > psas_pkg::LEN_BITS'(psas_pkg::DEPTH)) ?
                    psas_pkg::POS_BITS'(psas_pkg::DEPTH) : psas_pkg::POS_BITS'(len_ff);

   // request checks
   assign idx_bad   = (psas_pkg::POS_BITS'(index_ff) >= len_eff);
   assign range_bad = (start_ff > end_ff) || (end_ff > len_eff);

   // bisection probe and gallop probe
   assign half     = span_ff >> 1;
   assign probe    = lo_ff + half;
   assign gal_sum  = {1'b0, lo_ff} + {1'b0, step_ff};
   assign elem     = psas_pkg::KEY_BITS'(mem_rdata);
   assign go_right = (action_ff == psas_pkg::ACT_UPPER) ? (elem <= key_ff) : (elem < key_ff);

   assign scan_issue = cmd.max_run && (scan_cnt_ff < len_eff);

   // status to the controller
   always_comb begin
      status              = '0;
      status.action       = action_ff;
      status.span_zero    = (span_ff == '0);
      status.lo_ne_end    = (lo_ff != end_ff);
      status.go_right     = go_right;
      status.gal_in_range = (gal_sum < {1'b0, end_ff});
      status.ge_key       = (elem >= key_ff);
      status.max_done     = (scan_cnt_ff == len_eff) && !scan_pend_ff;
      status.clear_last   = (clear_cnt_ff == psas_pkg::ADDR_BITS'(psas_pkg::DEPTH - 1));
      unique case (action_ff)
         psas_pkg::ACT_WRITE, psas_pkg::ACT_READ: status.bad_req = idx_bad;
         psas_pkg::ACT_LOWER, psas_pkg::ACT_UPPER,
         psas_pkg::ACT_EXACT, psas_pkg::ACT_GALLOP: status.bad_req = range_bad;
         psas_pkg::ACT_MAX:                         status.bad_req = 1'b0;
         default:                                   status.bad_req = 1'b1;
      endcase
   end

   // memory address and write data
   always_comb begin
      unique case (cmd.addr_sel)
         psas_pkg::ADDR_INDEX:  mem_addr = index_ff;
         psas_pkg::ADDR_PROBE:  mem_addr = probe[psas_pkg::ADDR_BITS-1:0];
         psas_pkg::ADDR_LO:     mem_addr = lo_ff[psas_pkg::ADDR_BITS-1:0];
         psas_pkg::ADDR_GALLOP: mem_addr = gal_sum[psas_pkg::ADDR_BITS-1:0];
         psas_pkg::ADDR_SCAN:   mem_addr = scan_cnt_ff[psas_pkg::ADDR_BITS-1:0];
         psas_pkg::ADDR_CLEAR:  mem_addr = clear_cnt_ff;
         default:               mem_addr = index_ff;
      endcase
      mem_wdata = (cmd.addr_sel == psas_pkg::ADDR_CLEAR) ? '0 : key_ff[psas_pkg::ELEM_BITS-1:0];
   end

   psas_ram #(
      .WIDTH (psas_pkg::ELEM_BITS),
      .DEPTH (psas_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // result of the finishing transaction
   always_comb begin
      unique case (cmd.res_sel)
         psas_pkg::RES_ERROR: result_in = '0;
         psas_pkg::RES_KEY:   result_in = psas_pkg::RESULT_BITS'(key_ff[psas_pkg::ELEM_BITS-1:0]);
         psas_pkg::RES_RDATA: result_in = psas_pkg::RESULT_BITS'(mem_rdata);
         psas_pkg::RES_LO:    result_in = psas_pkg::RESULT_BITS'(lo_ff);
         psas_pkg::RES_LEN:   result_in = psas_pkg::RESULT_BITS'(len_eff);
         psas_pkg::RES_MAX:   result_in = psas_pkg::RESULT_BITS'(max_ff);
         psas_pkg::RES_EXACT: result_in = (elem == key_ff) ? psas_pkg::RESULT_BITS'(lo_ff) :
                                                             psas_pkg::RESULT_BITS'(len_eff);
         default:             result_in = '0;
      endcase
   end

   // control state: length register, clear sweep and scan tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         clear_cnt_ff <= '0;
         scan_pend_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            len_ff <= csr_write_data;
         end
         if (cmd.clear_run) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
         if (cmd.max_init) begin
            scan_pend_ff <= 1'b0;
         end else if (cmd.max_run) begin
            scan_pend_ff <= scan_issue;
         end
      end
   end

   // request latch, search window, scan and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= psas_pkg::action_type'(req_action);
         index_ff  <= req_index;
         key_ff    <= req_data_value;
         start_ff  <= req_range_start;
         end_ff    <= req_range_end;
      end
      unique case (cmd.span_op)
         psas_pkg::SPAN_RANGE: begin
            lo_ff   <= start_ff;
            span_ff <= end_ff - start_ff;
         end
         psas_pkg::SPAN_TAIL: begin
            span_ff <= end_ff - lo_ff;
         end
         psas_pkg::SPAN_STEP: begin
            span_ff <= step_ff;
         end
         psas_pkg::SPAN_BISECT: begin
            if (go_right) begin
               lo_ff   <= probe + 1'b1;
               span_ff <= span_ff - half - 1'b1;
            end else begin
               span_ff <= half;
            end
         end
         default: begin
         end
      endcase
      // gallop window
      if (cmd.gal_init) begin
         lo_ff   <= start_ff;
         step_ff <= psas_pkg::POS_BITS'(1);
      end else if (cmd.gal_step) begin
         lo_ff   <= gal_sum[psas_pkg::POS_BITS-1:0];
         step_ff <= step_ff << 1;
      end
      // max scan: address issued one cycle, compared the next
      if (cmd.max_init) begin
         scan_cnt_ff <= '0;
         max_ff      <= '0;
      end else if (cmd.max_run) begin
         if (scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (scan_pend_ff && (mem_rdata > max_ff)) begin
            max_ff <= mem_rdata;
         end
      end
      if (cmd.finish) begin
         result_ff <= result_in;
         error_ff  <= (cmd.res_sel == psas_pkg::RES_ERROR);
      end
   end

   assign rsp_result = result_ff;
   assign rsp_error  = error_ff;

endmodule

### hdl/packed_sorted_array_search.sv
// packed_sorted_array_search.sv
// top level of the sorted array search engine
// depends on psas_pkg, psas_ctrl, psas_dp (and through it psas_ram)
//
// Usage: a request is taken at a rising edge with start high and busy low;
// req_action selects write, read, lower bound, upper bound, exact search,
// galloping lower bound or max. Each transaction gives one response, shown on
// rsp_result and rsp_error for exactly one cycle with rsp_strobe high; the
// receiver cannot stall it. busy stays high until that response cycle.
// csr_write_enable/csr_write_data set the length in use; write it only while
// busy is low and no response is pending.
// Write and refused requests answer from the decode state, read after one memory
// read; lower and upper bound bisect the range one probe at a time, and exact
// search adds a read of the candidate when there is one; the galloping search
// probes lo+step, doubling step, while that stays inside the range, then bisects
// the bracketed span; max reads every entry in use.
// Each probe is one memory read and one compare.
// After reset the element memory is swept to zero, one entry a cycle, over all
// 1024 entries with busy high; csr writes are taken during the sweep.
module packed_sorted_array_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [psas_pkg::ACTION_BITS-1:0]      req_action,
   input  logic [psas_pkg::ADDR_BITS-1:0]        req_index,
   input  logic [psas_pkg::KEY_BITS-1:0]         req_data_value,
   input  logic [psas_pkg::POS_BITS-1:0]         req_range_start,
   input  logic [psas_pkg::POS_BITS-1:0]         req_range_end,
   output logic                                  rsp_strobe,
   output logic [psas_pkg::RESULT_BITS-1:0]      rsp_result,
   output logic                                  rsp_error,
   input  logic                                  csr_write_enable,
   input  logic [psas_pkg::LEN_BITS-1:0]         csr_write_data
);

   psas_pkg::ctrl_cmd_type  ctrl_cmd;
   psas_pkg::dp_status_type dp_status;

   // controller
   psas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (dp_status),
      .cmd        (ctrl_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // datapath
   psas_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .req_action       (req_action),
      .req_index        (req_index),
      .req_data_value   (req_data_value),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_result       (rsp_result),
      .rsp_error        (rsp_error)
   );

endmodule

### hdl/psas_checker.sv
// psas_checker.sv
// port-level checks of the sorted array search engine, bound to the top level
// depends on psas_pkg and packed_sorted_array_search_macros.svh
`include "packed_sorted_array_search_macros.svh"

module psas_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_strobe,
   input logic                             rsp_error,
   input logic [psas_pkg::RESULT_BITS-1:0] rsp_result
);

   // an accepted transaction keeps the block busy
   `PSAS_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)

   // a response ends the transaction, so strobes never come back to back
   `PSAS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

   // a response only follows a busy cycle
   `PSAS_ASSERT_NOW(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))

   // refused requests report zero
   `PSAS_ASSERT_NOW(a_error_result_zero, clock, reset, rsp_strobe && rsp_error, rsp_result == '0)

endmodule

bind packed_sorted_array_search psas_checker u_checker (.*);

### tb/sv/tb.sv
// tb.sv - self-checking testbench of the sorted array search engine
// drives requests and length writes, predicts every response, compares each one
// depends on psas_pkg and packed_sorted_array_search
`timescale 1ns / 100ps

module tb;
   import psas_pkg::*;

   localparam logic [ACTION_BITS-1:0] ACT_UNDEFINED = 3'd7;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int          REPORT_LIMIT = 10;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          FILL_MAX     = 48;

   typedef struct packed {
      logic [RESULT_BITS-1:0] result;
      logic                   error;
   } search_rsp_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic [ACTION_BITS-1:0] req_action       = '0;
   logic [ADDR_BITS-1:0]   req_index        = '0;
   logic [KEY_BITS-1:0]    req_data_value   = '0;
   logic [POS_BITS-1:0]    req_range_start  = '0;
   logic [POS_BITS-1:0]    req_range_end    = '0;
   logic                   csr_write_enable = 1'b0;
   logic [LEN_BITS-1:0]    csr_write_data   = '0;
   logic                   busy;
   logic                   rsp_strobe;
   logic [RESULT_BITS-1:0] rsp_result;
   logic                   rsp_error;

   // mirror of the block state
   logic [ELEM_BITS-1:0]   elements [DEPTH];
   logic [LEN_BITS-1:0]    length_reg = '0;

   search_rsp_type         expected_rsp_q [$];
   search_rsp_type         oldest_rsp;
   int                     mismatch_count = 0;
   int unsigned            cycle_count    = 0;

   packed_sorted_array_search dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_index        (req_index),
      .req_data_value   (req_data_value),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_result       (rsp_result),
      .rsp_error        (rsp_error),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned live_length();
      return (length_reg > DEPTH) ? DEPTH : length_reg;
   endfunction

   function automatic logic [ELEM_BITS-1:0] element_at(int unsigned pos);
      return (pos < DEPTH) ? elements[pos] : '0;
   endfunction

   // first position with element >= key, or > key when upper is set
   function automatic int unsigned bisect_position(logic [KEY_BITS-1:0] key,
                                                   int unsigned lo, int unsigned hi,
                                                   bit upper);
      int unsigned span;
      int unsigned half;
      int unsigned probe;
      logic [ELEM_BITS-1:0] e;
      bit go_right;
      span = hi - lo;
      while (span > 0) begin
         half     = span / 2;
         probe    = lo + half;
         e        = element_at(probe);
         go_right = upper ? (e <= key) : (e < key);
         if (go_right) begin
            lo   = probe + 1;
            span = span - (half + 1);
         end else begin
            span = half;
         end
      end
      return lo;
   endfunction

   // probes lo+1, lo+3, lo+7 ... then bisects the bracketed span
   function automatic int unsigned gallop_position(logic [KEY_BITS-1:0] key,
                                                   int unsigned lo, int unsigned hi);
      int unsigned step;
      step = 1;
      while (lo + step < hi) begin
         if (element_at(lo + step) >= key)
            return bisect_position(key, lo, lo + step, 1'b0);
         lo   = lo + step;
         step = step * 2;
      end
      return bisect_position(key, lo, hi, 1'b0);
   endfunction

   // response of one transaction, updating the mirror on a write
   function automatic search_rsp_type compute_response(logic [ACTION_BITS-1:0] action,
                                                       logic [ADDR_BITS-1:0] idx,
                                                       logic [KEY_BITS-1:0] key,
                                                       logic [POS_BITS-1:0] lo,
                                                       logic [POS_BITS-1:0] hi);
      search_rsp_type rsp;
      int unsigned len;
      int unsigned pos;
      int unsigned i;
      rsp = '0;
      len = live_length();
      case (action)
         ACT_WRITE, ACT_READ: begin
            if (idx >= len) begin
               rsp.error = 1'b1;
            end else if (action == ACT_WRITE) begin
               elements[idx] = key;
               rsp.result    = key;
            end else begin
               rsp.result = elements[idx];
            end
         end
         ACT_LOWER, ACT_UPPER, ACT_EXACT, ACT_GALLOP: begin
            if (lo > hi || hi > len) begin
               rsp.error = 1'b1;
            end else begin
               case (action)
                  ACT_LOWER: rsp.result = bisect_position(key, lo, hi, 1'b0);
                  ACT_UPPER: rsp.result = bisect_position(key, lo, hi, 1'b1);
                  ACT_EXACT: begin
                     pos = bisect_position(key, lo, hi, 1'b0);
                     rsp.result = (pos != hi && element_at(pos) == key) ? pos : len;
                  end
                  default:   rsp.result = gallop_position(key, lo, hi);
               endcase
            end
         end
         ACT_MAX: begin
            for (i = 0; i < len; i++)
               if (elements[i] > rsp.result)
                  rsp.result = elements[i];
         end
         default: rsp.error = 1'b1;
      endcase
      return rsp;
   endfunction

   // ---------------------------------------------------------------- driving

   // present one request and hold it until the block takes it
   task automatic issue_request(logic [ACTION_BITS-1:0] action,
                                logic [ADDR_BITS-1:0] idx,
                                logic [KEY_BITS-1:0] key,
                                logic [POS_BITS-1:0] lo,
                                logic [POS_BITS-1:0] hi);
      req_action      <= action;
      req_index       <= idx;
      req_data_value  <= key;
      req_range_start <= lo;
      req_range_end   <= hi;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      expected_rsp_q.push_back(compute_response(action, idx, key, lo, hi));
   endtask

   // random sender gap: with a chance of idle_pct percent, start drops and the sender waits
   task automatic sender_gap(int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // stop sending and let every pending response arrive
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      length_reg = value;
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [31:0] expected, logic [31:0] actual);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, expected, actual);
   endtask

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected response, result", '0, rsp_result);
         end else begin
            oldest_rsp = expected_rsp_q.pop_front();
            if (rsp_result !== oldest_rsp.result)
               report_mismatch("result", oldest_rsp.result, rsp_result);
            if (rsp_error !== oldest_rsp.error)
               report_mismatch("error flag", oldest_rsp.error, rsp_error);
         end
      end
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("packed_sorted_array_search regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // nothing in use after reset: accesses, a range past the length and an undefined code refused, empty searches answer
   task automatic test_reset_state();
      issue_request(ACT_WRITE, '0, 32'h1234_5678, '0, '0);
      issue_request(ACT_READ, '0, '0, '0, '0);
      issue_request(ACT_LOWER, '0, 32'd5, 11'd0, 11'd0);
      issue_request(ACT_EXACT, '0, 32'd0, 11'd0, 11'd0);
      issue_request(ACT_UPPER, '0, 32'd0, 11'd0, 11'd1);
      issue_request(ACT_MAX, '0, '0, '0, '0);
      issue_request(ACT_UNDEFINED, 10'h3FF, '1, '1, '1);
   endtask

   // full length, field extremes and each search flavor on a tiny sorted run
   task automatic test_limits();
      wait_idle();
      write_length(11'd1024);
      issue_request(ACT_WRITE, 10'd0, 32'd0, '0, '0);
      issue_request(ACT_WRITE, 10'd1, 32'd5, '0, '0);
      issue_request(ACT_WRITE, 10'd2, 32'd5, '0, '0);
      issue_request(ACT_WRITE, 10'd3, 32'd9, '0, '0);
      issue_request(ACT_WRITE, 10'd1023, 32'hFFFF_FFFF, '0, '0);
      issue_request(ACT_READ, 10'd1023, '0, '0, '0);
      issue_request(ACT_LOWER, '0, 32'd5, 11'd0, 11'd4);
      issue_request(ACT_UPPER, '0, 32'd5, 11'd0, 11'd4);
      issue_request(ACT_EXACT, '0, 32'd9, 11'd0, 11'd4);
      issue_request(ACT_EXACT, '0, 32'd6, 11'd0, 11'd4);
      issue_request(ACT_GALLOP, '0, 32'd9, 11'd0, 11'd4);
      issue_request(ACT_GALLOP, '0, 32'hFFFF_FFFF, 11'd0, 11'd1024);
      // start past end, then end past the length in use
      issue_request(ACT_UPPER, '0, 32'd5, 11'd5, 11'd4);
      issue_request(ACT_EXACT, '0, 32'd5, 11'd0, 11'd2047);
      issue_request(ACT_LOWER, '0, 32'd5, 11'd7, 11'd7);
      issue_request(ACT_MAX, '0, '0, '0, '0);
   endtask

   // a length above the depth acts as the depth
   task automatic test_oversized_length();
      wait_idle();
      write_length(11'd2047);
      issue_request(ACT_READ, 10'd1023, '0, '0, '0);
      issue_request(ACT_GALLOP, '0, 32'd5, 11'd0, 11'd1024);
      issue_request(ACT_LOWER, '0, 32'd5, 11'd0, 11'd1025);
      issue_request(ACT_MAX, '0, '0, '0, '0);
   endtask

   // rounds of: set a length, fill a sorted run, search it; some noise mixed in
   task automatic test_random_traffic(int idle_pct, int budget);
      int sent;
      int unsigned eff;
      int unsigned fill;
      int unsigned searches;
      int unsigned pick;
      logic [LEN_BITS-1:0]    len;
      logic [ELEM_BITS-1:0]   value;
      logic [1:0]             stride;
      logic [ACTION_BITS-1:0] action;
      logic [ADDR_BITS-1:0]   idx;
      logic [KEY_BITS-1:0]    key;
      logic [POS_BITS-1:0]    lo;
      logic [POS_BITS-1:0]    hi;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       len = 11'd1024;
            1:       len = LEN_BITS'($urandom_range(1025, 2047));
            2:       len = '0;
            default: len = LEN_BITS'($urandom_range(1, FILL_MAX));
         endcase
         wait_idle();
         write_length(len);
         eff  = live_length();
         fill = (eff < FILL_MAX) ? eff : FILL_MAX;

         // non-decreasing run with duplicates, sometimes close to the top
         value = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF80 : $urandom_range(0, 1000);
         for (int unsigned i = 0; i < fill; i++) begin
            issue_request(ACT_WRITE, ADDR_BITS'(i), value, '0, '0);
            sent++;
            sender_gap(idle_pct);
            stride = 2'($urandom_range(0, 3));
            if (32'hFFFF_FFFF - value >= stride)
               value = value + stride;
         end

         searches = $urandom_range(10, 30);
         for (int unsigned s = 0; s < searches; s++) begin
            if ($urandom_range(0, 3) != 0) begin
               action = ACTION_BITS'($urandom_range(ACT_READ, ACT_MAX));
               idx    = (fill > 0) ? ADDR_BITS'($urandom_range(0, fill - 1)) : '0;
               lo     = POS_BITS'($urandom_range(0, fill));
               hi     = ($urandom_range(0, 3) == 0) ? POS_BITS'($urandom_range(lo, eff))
                                                    : POS_BITS'($urandom_range(lo, fill));
               pick   = $urandom_range(0, 3);
               if (pick == 0 || fill == 0)
                  key = $urandom;
               else
                  key = elements[$urandom_range(0, fill - 1)] + pick - 2;
            end else begin
               action = ACTION_BITS'($urandom_range(0, 7));
               idx    = ADDR_BITS'($urandom);
               key    = $urandom;
               lo     = POS_BITS'($urandom);
               hi     = POS_BITS'($urandom);
            end
            issue_request(action, idx, key, lo, hi);
            sent++;
            // now and then hold off until everything has drained
            if ($urandom_range(0, 19) == 0)
               wait_idle();
            else
               sender_gap(idle_pct);
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      foreach (elements[i]) elements[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_limits();
      test_oversized_length();
      test_random_traffic(0, 160);
      test_random_traffic(50, 160);
      test_random_traffic(15, 160);
      wait_idle();
      if (mismatch_count == 0)
         $display("packed_sorted_array_search regression: pass");
      else
         $display("packed_sorted_array_search regression: fail");
      $finish;
   end

endmodule

### packed_sorted_array_search.f
+incdir+hdl
hdl/psas_pkg.sv
hdl/psas_ram.sv
hdl/psas_ctrl.sv
hdl/psas_dp.sv
hdl/packed_sorted_array_search.sv
hdl/psas_checker.sv
tb/sv/tb.sv
